>>> hdl/segment_sphere_hit_test_defines.svh
// Assertion macros for the segment / sphere hit test checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SEGMENT_SPHERE_HIT_TEST_DEFINES_SVH
`define SEGMENT_SPHERE_HIT_TEST_DEFINES_SVH

// Clocked check, disabled while reset is applied
`define SSHT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("segment_sphere_hit_test check failed");

// Same check, also evaluated while reset is applied
`define SSHT_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("segment_sphere_hit_test check failed");

`endif

>>> hdl/sshit_pkg.sv
// Shared widths and types for the segment / sphere hit test.
// No dependencies.
`default_nettype none
package sshit_pkg;
	localparam int CW = 32;           // coordinate width
	localparam int RW = 31;           // radius width
	localparam int DW = CW + 1;       // difference width
	localparam int PW = 2 * DW;       // product of two differences
	localparam int SW = PW + 2;       // A, B, C
	localparam int HW = SW / 2;       // half of an A, B or C word
	localparam int FW = SW + 2;       // A + 2B + C
	localparam int QW = 2 * SW + 2;   // B*B and A*C

	typedef logic signed [SW-1:0] sum_t;
endpackage
`default_nettype wire

>>> hdl/sshit_sqcmp.sv
// Pipelined test of B*B >= A*C, three stages (s4 to s6).
// Depends on sshit_pkg.
`default_nettype none
module sshit_sqcmp import sshit_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire sum_t a,
	input  wire sum_t b,
	input  wire sum_t c,
	output logic      ge_s6
);
	sum_t x [2];
	sum_t y [2];
	logic signed [2*HW-1:0]   hh_s4 [2];
	logic signed [2*HW:0]     hl_s4 [2];
	logic signed [2*HW:0]     lh_s4 [2];
	logic signed [2*HW+1:0]   ll_s4 [2];
	logic signed [QW-1:0]     p_s5  [2];
	logic signed [QW-1:0]     diff;

	assign x[0] = b;
	assign y[0] = b;
	assign x[1] = a;
	assign y[1] = c;

	// Form partial products of the two squares-and-products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				hh_s4[i] <= $signed(x[i][SW-1:HW]) * $signed(y[i][SW-1:HW]);
				hl_s4[i] <= $signed(x[i][SW-1:HW]) * $signed({1'b0, y[i][HW-1:0]});
				lh_s4[i] <= $signed({1'b0, x[i][HW-1:0]}) * $signed(y[i][SW-1:HW]);
				ll_s4[i] <= $signed({1'b0, x[i][HW-1:0]}) * $signed({1'b0, y[i][HW-1:0]});
			end
		end
	end

	// Combine partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				p_s5[i] <= (QW'(hh_s4[i]) <<< (2 * HW))
					+ ((QW'(hl_s4[i]) + QW'(lh_s4[i])) <<< HW)
					+ QW'(ll_s4[i]);
			end
		end
	end

	// Compare by sign of the difference
	assign diff = p_s5[0] - p_s5[1];

	always_ff @(posedge clk) begin
		if (en) begin
			ge_s6 <= ~diff[QW-1];
		end
	end
endmodule
`default_nettype wire

>>> hdl/segment_sphere_hit_test.sv
// Segment / sphere surface hit test, one item per cycle when not stalled.
// Input item: segment start and end and sphere center (signed Q16.16) and
// radius (unsigned Q15.16), on in_valid / in_stall. Result item: hit and
// zero_length on out_valid / out_stall. An item is taken on a clock edge
// with valid high and stall low.
// An accepted item runs through the seven-stage pipeline (differences,
// products, sums, partial products of B*B and A*C, their combination, the
// compare, the result register); throughput is one item per cycle while
// the receiver does not stall a waiting result.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the pipeline then accepts at once.
// Depends on sshit_pkg and sshit_sqcmp.
`default_nettype none
module segment_sphere_hit_test import sshit_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic signed [CW-1:0] start_x,
	input  wire logic signed [CW-1:0] start_y,
	input  wire logic signed [CW-1:0] start_z,
	input  wire logic signed [CW-1:0] end_x,
	input  wire logic signed [CW-1:0] end_y,
	input  wire logic signed [CW-1:0] end_z,
	input  wire logic signed [CW-1:0] center_x,
	input  wire logic signed [CW-1:0] center_y,
	input  wire logic signed [CW-1:0] center_z,
	input  wire logic [RW-1:0]        sphere_radius,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      hit,
	output logic                      zero_length
);
	typedef struct packed {
		logic zl;
		logic c_neg;
		logic c_le0;
		logic f_neg;
		logic f_le0;
		logic in_span;
	} flag_t;

	logic en;
	logic [5:0] valid_s;   // valid of s1..s6

	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] m_s1 [3];
	logic [RW-1:0]        r_s1;
	logic signed [PW-1:0] dd_s2 [3];
	logic signed [PW-1:0] dm_s2 [3];
	logic signed [PW-1:0] mm_s2 [3];
	logic [2*RW-1:0]      rr_s2;
	sum_t a_s3, b_s3, c_s3;
	logic signed [FW-1:0] f1;
	logic signed [SW:0]   ab;
	flag_t flag_s4, flag_s5, flag_s6;
	logic  ge_s6;

	// Hold everything while a result waits on a stalled receiver
	assign en       = ~(out_valid & out_stall);
	assign in_stall = ~en;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s   <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s   <= {valid_s[4:0], in_valid};
			out_valid <= valid_s[5];
		end
	end

	// Stage 1: differences
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= DW'(end_x) - DW'(start_x);
			d_s1[1] <= DW'(end_y) - DW'(start_y);
			d_s1[2] <= DW'(end_z) - DW'(start_z);
			m_s1[0] <= DW'(start_x) - DW'(center_x);
			m_s1[1] <= DW'(start_y) - DW'(center_y);
			m_s1[2] <= DW'(start_z) - DW'(center_z);
			r_s1    <= sphere_radius;
		end
	end

	// Stage 2: component products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= d_s1[i] * d_s1[i];
				dm_s2[i] <= d_s1[i] * m_s1[i];
				mm_s2[i] <= m_s1[i] * m_s1[i];
			end
			rr_s2 <= r_s1 * r_s1;
		end
	end

	// Stage 3: dot products
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= SW'(dd_s2[0]) + SW'(dd_s2[1]) + SW'(dd_s2[2]);
			b_s3 <= SW'(dm_s2[0]) + SW'(dm_s2[1]) + SW'(dm_s2[2]);
			c_s3 <= SW'(mm_s2[0]) + SW'(mm_s2[1]) + SW'(mm_s2[2])
				- SW'($signed({1'b0, rr_s2}));
		end
	end

	// Stage 4: end values of f and vertex range
	assign f1 = FW'(a_s3) + (FW'(b_s3) <<< 1) + FW'(c_s3);
	assign ab = (SW + 1)'(a_s3) + (SW + 1)'(b_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			flag_s4.zl      <= (a_s3 == '0);
			flag_s4.c_neg   <= c_s3[SW-1];
			flag_s4.c_le0   <= c_s3[SW-1] | (c_s3 == '0);
			flag_s4.f_neg   <= f1[FW-1];
			flag_s4.f_le0   <= f1[FW-1] | (f1 == '0);
			flag_s4.in_span <= b_s3[SW-1] & ~ab[SW] & (ab != '0);
			flag_s5         <= flag_s4;
			flag_s6         <= flag_s5;
		end
	end

	sshit_sqcmp u_sqcmp (
		.clk   (clk),
		.en    (en),
		.a     (a_s3),
		.b     (b_s3),
		.c     (c_s3),
		.ge_s6 (ge_s6)
	);

	// Stage 7: decide and register the result
	always_ff @(posedge clk) begin
		if (en) begin
			zero_length <= flag_s6.zl;
			if (flag_s6.zl) begin
				hit <= flag_s6.c_le0;
			end else if (flag_s6.c_neg && flag_s6.f_neg) begin
				hit <= 1'b0;
			end else if (flag_s6.c_le0 || flag_s6.f_le0) begin
				hit <= 1'b1;
			end else begin
				hit <= flag_s6.in_span & ge_s6;
			end
		end
	end
endmodule
`default_nettype wire

>>> hdl/sshit_checker.sv
// Port-level checks for segment_sphere_hit_test, bound to the top level.
// Depends on segment_sphere_hit_test_defines.svh.
`default_nettype none
`include "segment_sphere_hit_test_defines.svh"
module sshit_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [31:0] start_x,
	input wire logic [31:0] start_y,
	input wire logic [31:0] start_z,
	input wire logic [31:0] end_x,
	input wire logic [31:0] end_y,
	input wire logic [31:0] end_z,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        hit,
	input wire logic        zero_length
);
	// A stalled result holds
	`SSHT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(hit) && $stable(zero_length))
	// Input stalls only behind a stalled result
	`SSHT_ASSERT_ALWAYS(a_in_stall_cause, in_stall |-> out_valid && out_stall)
	// A degenerate segment accepted with no stall after it shows up flagged as zero length
	`SSHT_ASSERT(a_zero_length, $past(in_valid && !in_stall && start_x == end_x && start_y == end_y && start_z == end_z, 7) && $past(!in_stall, 6) && $past(!in_stall, 5) && $past(!in_stall, 4) && $past(!in_stall, 3) && $past(!in_stall, 2) && $past(!in_stall, 1) |-> out_valid && zero_length)
endmodule

bind segment_sphere_hit_test sshit_checker u_sshit_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.start_x     (start_x),
	.start_y     (start_y),
	.start_z     (start_z),
	.end_x       (end_x),
	.end_y       (end_y),
	.end_z       (end_z),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.hit         (hit),
	.zero_length (zero_length)
);
`default_nettype wire

>>> tb/testbench.sv
// Testbench for segment_sphere_hit_test: random and directed segment/sphere items,
// checked against an exact wide-integer hit predictor held in a scoreboard class.
// Depends on sshit_pkg and the segment_sphere_hit_test RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import sshit_pkg::*;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [199:0] big_t;

	typedef struct {
		coord_t sx, sy, sz, ex, ey, ez, cx, cy, cz;
		logic [RW-1:0] rad;
	} seg_item_t;

	typedef struct {
		logic hit;
		logic zl;
	} hit_result_t;

	// Hold the expected hit results and compare arriving ones
	class hit_scoreboard;
		hit_result_t pending[$];
		int errors;

		function hit_result_t predict_hit(seg_item_t it);
			big_t dx, dy, dz, mx, my, mz, r, a, b, c, f1;
			hit_result_t res;
			dx = big_t'(it.ex) - big_t'(it.sx);
			dy = big_t'(it.ey) - big_t'(it.sy);
			dz = big_t'(it.ez) - big_t'(it.sz);
			mx = big_t'(it.sx) - big_t'(it.cx);
			my = big_t'(it.sy) - big_t'(it.cy);
			mz = big_t'(it.sz) - big_t'(it.cz);
			r = big_t'({1'b0, it.rad});
			a = dx * dx + dy * dy + dz * dz;
			b = dx * mx + dy * my + dz * mz;
			c = mx * mx + my * my + mz * mz - r * r;
			res.zl = (a == 0);
			if (res.zl) begin
				res.hit = (c <= 0);
			end else begin
				f1 = a + b + b + c;
				if (c < 0 && f1 < 0)
					res.hit = 0;
				else if (c <= 0 || f1 <= 0)
					res.hit = 1;
				else
					res.hit = (b < 0) && (a + b > 0) && (b * b - a * c >= 0);
			end
			return res;
		endfunction

		function void note_item(seg_item_t it);
			pending.insert(pending.size(), predict_hit(it));
		endfunction

		function void check_result(logic h, logic z);
			hit_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result hit=%b zero_length=%b", $realtime, h, z);
				errors++;
				return;
			end
			e = pending[0];
			pending.delete(0);
			if (h !== e.hit) begin
				$display("%0t: hit expected %b actual %b", $realtime, e.hit, h);
				errors++;
			end
			if (z !== e.zl) begin
				$display("%0t: zero_length expected %b actual %b", $realtime, e.zl, z);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic out_stall = 0;
	coord_t start_x = 0, start_y = 0, start_z = 0, end_x = 0, end_y = 0, end_z = 0;
	coord_t center_x = 0, center_y = 0, center_z = 0;
	logic [RW-1:0] sphere_radius = 0;
	logic in_stall, out_valid, hit, zero_length;
	hit_scoreboard sb;
	longint cycles = 0;
	bit feeding_done = 0;

	segment_sphere_hit_test u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.end_x(end_x), .end_y(end_y), .end_z(end_z),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.sphere_radius(sphere_radius),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .zero_length(zero_length)
	);

	always #1 clk = ~clk;

	// Pick a gap length: mostly none or short, sometimes long
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Present one item and hold it until accepted; drop valid only for a gap
	task automatic send_item(seg_item_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		start_x <= it.sx; start_y <= it.sy; start_z <= it.sz;
		end_x <= it.ex; end_y <= it.ey; end_z <= it.ez;
		center_x <= it.cx; center_y <= it.cy; center_z <= it.cz;
		sphere_radius <= it.rad;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(it);
	endtask

	function automatic coord_t rand_coord(int scale);
		case (scale)
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
			2: return coord_t'($signed($urandom_range(0, 40)) - 20) <<< 16;
			default: return coord_t'($signed($urandom_range(0, 8)) - 4);
		endcase
	endfunction

	// Build a random item; small scales give a realistic hit/miss mix
	function automatic seg_item_t rand_item();
		seg_item_t it;
		int s;
		s = $urandom_range(0, 3);
		it.sx = rand_coord(s); it.sy = rand_coord(s); it.sz = rand_coord(s);
		it.cx = rand_coord(s); it.cy = rand_coord(s); it.cz = rand_coord(s);
		if ($urandom_range(0, 9) == 0) begin
			it.ex = it.sx; it.ey = it.sy; it.ez = it.sz;
		end else begin
			it.ex = rand_coord(s); it.ey = rand_coord(s); it.ez = rand_coord(s);
		end
		case (s)
			0: it.rad = RW'($urandom);
			1: it.rad = RW'($urandom_range(0, 1000) << 16);
			2: it.rad = RW'($urandom_range(0, 20) << 16);
			default: it.rad = RW'($urandom_range(0, 5));
		endcase
		return it;
	endfunction

	function automatic seg_item_t mk(int sx, int sy, int sz, int ex, int ey, int ez,
			int cx, int cy, int cz, int r);
		seg_item_t it;
		it.sx = sx; it.sy = sy; it.sz = sz; it.ex = ex; it.ey = ey; it.ez = ez;
		it.cx = cx; it.cy = cy; it.cz = cz; it.rad = RW'(r);
		return it;
	endfunction

	// Drive stimulus: directed cases then random items
	initial begin
		int mn, mx;
		mn = 32'h8000_0000; mx = 32'h7fff_ffff;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));          // zero length on point
		send_item(mk(1, 0, 0, 1, 0, 0, 0, 0, 0, 5));          // zero length inside
		send_item(mk(9, 0, 0, 9, 0, 0, 0, 0, 0, 5));          // zero length outside
		send_item(mk(5, 0, 0, 5, 0, 0, 0, 0, 0, 5));          // zero length on surface
		send_item(mk(-10, 5, 0, 10, 5, 0, 0, 0, 0, 5));       // tangent
		send_item(mk(-10, 6, 0, 10, 6, 0, 0, 0, 0, 5));       // near miss
		send_item(mk(5, 0, 0, 20, 0, 0, 0, 0, 0, 5));         // endpoint on surface
		send_item(mk(-1, 0, 0, 1, 0, 0, 0, 0, 0, 5));         // wholly inside
		send_item(mk(-10, 0, 0, 10, 0, 0, 0, 0, 0, 5));       // crossing both sides
		send_item(mk(-10, 0, 0, 10, 0, 0, 0, 0, 0, 0));       // zero radius through center
		send_item(mk(-10, 1, 0, 10, 1, 0, 0, 0, 0, 0));       // zero radius miss
		send_item(mk(10, 0, 0, 20, 0, 0, 0, 0, 0, 5));        // pointing away
		send_item(mk(mn, mn, mn, mx, mx, mx, mx, mn, mx, 31'h7fff_ffff));
		send_item(mk(mx, mx, mx, mn, mn, mn, mn, mn, mn, 0));
		send_item(mk(mn, mn, mn, mn, mn, mn, mx, mx, mx, 31'h7fff_ffff));
		send_item(mk(mx, mn, mx, mn, mx, mn, 0, 0, 0, 31'h7fff_ffff));
		send_item(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, 31'h7fff_ffff));
		repeat (800) send_item(rand_item());
		in_valid <= 0;
		feeding_done = 1;
	end

	// Stall the receiver at random, with stall-free stretches
	initial begin
		int g;
		forever begin
			out_stall <= 0;
			g = ($urandom_range(0, 3) == 0) ? 40 : gap_len();
			repeat (g + 1) @(posedge clk);
			out_stall <= 1;
			repeat (gap_len() + 1) @(posedge clk);
		end
	end

	// Check results on acceptance
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(hit, zero_length);
	end

	// End of run and timeout
	initial begin
		wait (sb != null);
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 200000) begin
				$display("end of test: mismatches");
				$finish;
			end
			if (feeding_done && sb.pending.size() == 0) begin
				repeat (20) @(posedge clk);
				if (sb.errors == 0 && sb.pending.size() == 0)
					$display("end of test: clean");
				else
					$display("end of test: mismatches");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire

>>> segment_sphere_hit_test.f
+incdir+hdl
hdl/sshit_pkg.sv
hdl/sshit_sqcmp.sv
hdl/segment_sphere_hit_test.sv
hdl/sshit_checker.sv
tb/testbench.sv
